### design/crc_framed_response_parser_assert.svh
// assertion macros for the framed response parser checker
`ifndef CRC_FRAMED_RESPONSE_PARSER_ASSERT_SVH
`define CRC_FRAMED_RESPONSE_PARSER_ASSERT_SVH

// clocked assertion, disabled while reset is low
`define CFRP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cfrp assertion failed");

// same, with a caller message
`define CFRP_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`endif

### design/cfrp_pkg.sv
// types, constants and crc function for the framed response parser
package cfrp_pkg;

  localparam logic [15:0] CrcPoly       = 16'h1021;
  localparam logic [7:0]  StartByteRst  = 8'd46;
  localparam logic [8:0]  LenZeroMeans  = 9'd256;

  localparam logic [8:0]  PosWait       = 9'd0;
  localparam logic [8:0]  PosCommand    = 9'd1;
  localparam logic [8:0]  PosAddrHi     = 9'd2;
  localparam logic [8:0]  PosAddrLo     = 9'd3;
  localparam logic [8:0]  PosLength     = 9'd4;
  localparam logic [8:0]  PosPayload    = 9'd5;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_FRAME_OK  = 2'd1,
    KIND_CRC_BAD   = 2'd2,
    KIND_BAD_START = 2'd3
  } result_kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       abandon;
  } item_t;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   payload_byte;
    logic [7:0]   payload_index;
    logic [7:0]   command;
    logic [15:0]  address;
    logic [8:0]   param_count;
    logic [7:0]   ack_code;
    logic [15:0]  received_checksum;
    logic [15:0]  computed_checksum;
  } result_t;

  // crc16 xmodem, one byte, msb first
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### design/cfrp_in_stage.sv
// input register stage for received bytes
module cfrp_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cfrp_pkg::item_t in_item_i,
  input  logic            advance_i,
  output logic            item_valid_o,
  output cfrp_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  cfrp_pkg::item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### design/cfrp_parser.sv
// frame position tracking, crc update and result forming
module cfrp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              item_valid_i,
  input  cfrp_pkg::item_t   item_i,
  input  logic              advance_i,
  output logic              res_valid_o,
  output cfrp_pkg::result_t res_o
);

  logic [7:0]  start_q;
  logic [8:0]  pos_q, pos_d;
  logic [8:0]  total_q, total_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  ack_q, ack_d;
  logic [15:0] cks_q, cks_d;

  logic        fire;
  logic [7:0]  b;
  logic [8:0]  pos_eff;
  logic [15:0] crc_eff;
  logic [15:0] crc_next;
  logic [8:0]  ack_pos;
  logic [8:0]  idx_full;
  logic [15:0] cks_full;
  logic        hit;

  assign fire     = item_valid_i && advance_i;
  assign b        = item_i.rx_byte;
  assign pos_eff  = item_i.abandon ? cfrp_pkg::PosWait : pos_q;
  assign crc_eff  = item_i.abandon ? 16'h0000 : crc_q;
  assign crc_next = cfrp_pkg::crc16_step(crc_eff, b);
  assign ack_pos  = total_q + cfrp_pkg::PosPayload;
  assign idx_full = pos_eff - cfrp_pkg::PosPayload;
  assign cks_full = {cks_q[15:8], b};

  always_comb begin
    pos_d   = pos_eff;
    crc_d   = crc_eff;
    total_d = total_q;
    cmd_d   = cmd_q;
    addr_d  = addr_q;
    ack_d   = ack_q;
    cks_d   = cks_q;
    hit     = 1'b0;
    res_o   = '0;
    if (pos_eff == cfrp_pkg::PosWait) begin
      if (b != start_q) begin
        hit        = 1'b1;
        res_o.kind = cfrp_pkg::KIND_BAD_START;
      end else begin
        crc_d = crc_next;
        pos_d = cfrp_pkg::PosCommand;
      end
    end else if (pos_eff == cfrp_pkg::PosCommand) begin
      cmd_d = b;
      crc_d = crc_next;
      pos_d = pos_eff + 9'd1;
    end else if (pos_eff == cfrp_pkg::PosAddrHi) begin
      addr_d = {b, 8'h00};
      crc_d  = crc_next;
      pos_d  = pos_eff + 9'd1;
    end else if (pos_eff == cfrp_pkg::PosAddrLo) begin
      addr_d = {addr_q[15:8], b};
      crc_d  = crc_next;
      pos_d  = pos_eff + 9'd1;
    end else if (pos_eff == cfrp_pkg::PosLength) begin
      total_d = (b == 8'h00) ? cfrp_pkg::LenZeroMeans : {1'b0, b};
      crc_d   = crc_next;
      pos_d   = pos_eff + 9'd1;
    end else if (pos_eff < ack_pos) begin
      hit                 = 1'b1;
      res_o.kind          = cfrp_pkg::KIND_PAYLOAD;
      res_o.payload_byte  = b;
      res_o.payload_index = idx_full[7:0];
      crc_d               = crc_next;
      pos_d               = pos_eff + 9'd1;
    end else if (pos_eff == ack_pos) begin
      ack_d = b;
      crc_d = crc_next;
      pos_d = pos_eff + 9'd1;
    end else if (pos_eff == ack_pos + 9'd1) begin
      cks_d = {b, 8'h00};
      pos_d = pos_eff + 9'd1;
    end else begin
      cks_d                   = cks_full;
      hit                     = 1'b1;
      res_o.kind              = (cks_full == crc_eff) ? cfrp_pkg::KIND_FRAME_OK
                                                      : cfrp_pkg::KIND_CRC_BAD;
      res_o.command           = cmd_q;
      res_o.address           = addr_q;
      res_o.param_count       = total_q;
      res_o.ack_code          = ack_q;
      res_o.received_checksum = cks_full;
      res_o.computed_checksum = crc_eff;
      pos_d                   = cfrp_pkg::PosWait;
      crc_d                   = 16'h0000;
    end
  end

  assign res_valid_o = item_valid_i && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= cfrp_pkg::StartByteRst;
      pos_q   <= cfrp_pkg::PosWait;
      total_q <= '0;
      crc_q   <= '0;
      cmd_q   <= '0;
      addr_q  <= '0;
      ack_q   <= '0;
      cks_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      if (fire) begin
        pos_q   <= pos_d;
        total_q <= total_d;
        crc_q   <= crc_d;
        cmd_q   <= cmd_d;
        addr_q  <= addr_d;
        ack_q   <= ack_d;
        cks_q   <= cks_d;
      end
    end
  end

endmodule

### design/cfrp_out_stage.sv
// result register with downstream handshake
module cfrp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  cfrp_pkg::result_t res_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cfrp_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  cfrp_pkg::result_t res_q;

  assign advance_o = !valid_q || out_ready_i;
  assign valid_d   = advance_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

### design/crc_framed_response_parser.sv
// top level of the length-prefixed crc16 framed response parser
// Takes one received byte per cycle while results drain, and gives at most
// one result per byte: a payload byte with its index, a frame summary with
// the checksum verdict, or a bad start byte report. A byte passes an input
// register, then the parsing logic (including the unrolled eight-bit
// CRC16-XMODEM update) into the result register, and a new byte is taken
// every cycle while results are drained. Setting abandon_i throws away any
// partial frame before that byte is parsed. The start byte value is to be
// written through cfg_we_i/cfg_wdata_i while the block is idle; the block
// itself does not enforce this. It resets to 46.
module crc_framed_response_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        abandon_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  payload_index_o,
  output logic [7:0]  command_o,
  output logic [15:0] address_o,
  output logic [8:0]  param_count_o,
  output logic [7:0]  ack_code_o,
  output logic [15:0] received_checksum_o,
  output logic [15:0] computed_checksum_o
);

  cfrp_pkg::item_t   in_item;
  cfrp_pkg::item_t   item;
  cfrp_pkg::result_t res;
  cfrp_pkg::result_t out_res;
  logic              item_valid;
  logic              res_valid;
  logic              advance;

  assign in_item.rx_byte = rx_byte_i;
  assign in_item.abandon = abandon_i;

  cfrp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  cfrp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .advance_i    (advance),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  cfrp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign result_kind_o       = out_res.kind;
  assign payload_byte_o      = out_res.payload_byte;
  assign payload_index_o     = out_res.payload_index;
  assign command_o           = out_res.command;
  assign address_o           = out_res.address;
  assign param_count_o       = out_res.param_count;
  assign ack_code_o          = out_res.ack_code;
  assign received_checksum_o = out_res.received_checksum;
  assign computed_checksum_o = out_res.computed_checksum;

endmodule

### design/cfrp_checker.sv
// port-level checker for the framed response parser, with its bind
`include "crc_framed_response_parser_assert.svh"

module cfrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  result_kind_o,
  input logic [7:0]  payload_byte_o,
  input logic [7:0]  payload_index_o,
  input logic [7:0]  command_o,
  input logic [15:0] address_o,
  input logic [8:0]  param_count_o,
  input logic [7:0]  ack_code_o,
  input logic [15:0] received_checksum_o,
  input logic [15:0] computed_checksum_o
);

  logic is_summary;
  logic is_payload;
  logic out_stall;
  logic is_ok;
  logic crc_match;
  logic summary_zero;
  logic payload_zero;

  assign is_summary = out_valid_o && (result_kind_o == cfrp_pkg::KIND_FRAME_OK ||
                                      result_kind_o == cfrp_pkg::KIND_CRC_BAD);
  assign is_payload = out_valid_o && (result_kind_o == cfrp_pkg::KIND_PAYLOAD);
  assign out_stall  = out_valid_o && !out_ready_i;
  assign is_ok      = (result_kind_o == cfrp_pkg::KIND_FRAME_OK);
  assign crc_match  = (received_checksum_o == computed_checksum_o);
  assign summary_zero = command_o == 8'd0 && address_o == 16'd0 && param_count_o == 9'd0 &&
                        ack_code_o == 8'd0 && received_checksum_o == 16'd0 &&
                        computed_checksum_o == 16'd0;
  assign payload_zero = payload_byte_o == 8'd0 && payload_index_o == 8'd0;

  // stalled result transfer holds
  `CFRP_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(result_kind_o) && $stable(payload_byte_o) && $stable(computed_checksum_o))

  // verdict agrees with the two checksums
  `CFRP_ASSERT_MSG(a_verdict, clk_i, rst_ni, is_summary |-> (is_ok == crc_match), "checksum verdict wrong")

  // summary carries a decoded length of 1 to 256
  `CFRP_ASSERT_MSG(a_count, clk_i, rst_ni, is_summary |-> (param_count_o != 9'd0) && (param_count_o <= 9'd256), "param count out of range")

  // payload result has zero summary fields
  `CFRP_ASSERT(a_payload_clean, clk_i, rst_ni, is_payload |-> summary_zero)

  // non-payload result has zero payload fields
  `CFRP_ASSERT(a_other_clean, clk_i, rst_ni, out_valid_o && !is_payload |-> payload_zero)

endmodule

bind crc_framed_response_parser cfrp_checker u_cfrp_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .result_kind_o       (result_kind_o),
  .payload_byte_o      (payload_byte_o),
  .payload_index_o     (payload_index_o),
  .command_o           (command_o),
  .address_o           (address_o),
  .param_count_o       (param_count_o),
  .ack_code_o          (ack_code_o),
  .received_checksum_o (received_checksum_o),
  .computed_checksum_o (computed_checksum_o)
);

### dv/tb_crc_framed_response_parser.sv
// testbench for the crc16 framed response parser: frame stimulus with scoreboard check
module tb_crc_framed_response_parser;
  timeunit 1ns;
  timeprecision 1ps;

  class frame_scoreboard;
    logic [7:0]        start_val;
    logic [8:0]        byte_pos;
    logic [8:0]        pay_len;
    logic [15:0]       run_crc;
    logic [7:0]        cmd_q;
    logic [15:0]       addr_q;
    logic [7:0]        ack_q;
    logic [15:0]       trailer_q;
    cfrp_pkg::result_t expected_results[$];
    int                mismatches;
    int                n_payload;
    int                n_frame_ok;
    int                n_crc_bad;
    int                n_bad_start;

    function new();
      start_val   = cfrp_pkg::StartByteRst;
      byte_pos    = cfrp_pkg::PosWait;
      pay_len     = '0;
      run_crc     = '0;
      cmd_q       = '0;
      addr_q      = '0;
      ack_q       = '0;
      trailer_q   = '0;
      mismatches  = 0;
      n_payload   = 0;
      n_frame_ok  = 0;
      n_crc_bad   = 0;
      n_bad_start = 0;
    endfunction

    // crc16 xmodem, shifted one bit at a time
    function logic [15:0] crc_update(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int k = 7; k >= 0; k--) begin
        fb = c[15] ^ d[k];
        c  = {c[14:0], 1'b0};
        if (fb) c ^= cfrp_pkg::CrcPoly;
      end
      return c;
    endfunction

    function void note_byte(logic [7:0] b, logic ab);
      cfrp_pkg::result_t r;
      r = '0;
      if (ab) begin
        byte_pos = cfrp_pkg::PosWait;
        run_crc  = '0;
      end
      if (byte_pos == cfrp_pkg::PosWait) begin
        if (b != start_val) begin
          r.kind = cfrp_pkg::KIND_BAD_START;
          expected_results.push_back(r);
        end else begin
          run_crc  = crc_update(16'h0000, b);
          byte_pos = cfrp_pkg::PosCommand;
        end
        return;
      end
      if (byte_pos == cfrp_pkg::PosCommand) begin
        cmd_q = b;
      end else if (byte_pos == cfrp_pkg::PosAddrHi) begin
        addr_q[15:8] = b;
      end else if (byte_pos == cfrp_pkg::PosAddrLo) begin
        addr_q[7:0] = b;
      end else if (byte_pos == cfrp_pkg::PosLength) begin
        pay_len = (b == 8'd0) ? cfrp_pkg::LenZeroMeans : {1'b0, b};
      end else if (byte_pos < cfrp_pkg::PosPayload + pay_len) begin
        r.kind          = cfrp_pkg::KIND_PAYLOAD;
        r.payload_byte  = b;
        r.payload_index = 8'(byte_pos - cfrp_pkg::PosPayload);
        expected_results.push_back(r);
      end else if (byte_pos == cfrp_pkg::PosPayload + pay_len) begin
        ack_q = b;
      end else if (byte_pos == cfrp_pkg::PosPayload + pay_len + 9'd1) begin
        trailer_q[15:8] = b;
        byte_pos = byte_pos + 9'd1;
        return;
      end else begin
        trailer_q[7:0]      = b;
        r.kind              = (trailer_q == run_crc) ? cfrp_pkg::KIND_FRAME_OK
                                                     : cfrp_pkg::KIND_CRC_BAD;
        r.command           = cmd_q;
        r.address           = addr_q;
        r.param_count       = pay_len;
        r.ack_code          = ack_q;
        r.received_checksum = trailer_q;
        r.computed_checksum = run_crc;
        expected_results.push_back(r);
        byte_pos = cfrp_pkg::PosWait;
        run_crc  = '0;
        return;
      end
      run_crc  = crc_update(run_crc, b);
      byte_pos = byte_pos + 9'd1;
    endfunction

    function string fmt(cfrp_pkg::result_t r);
      return $sformatf({"kind %0d byte %02h idx %0d cmd %02h addr %04h cnt %0d ack %02h",
                        " rx_crc %04h calc_crc %04h"}, r.kind, r.payload_byte,
                       r.payload_index, r.command, r.address, r.param_count, r.ack_code,
                       r.received_checksum, r.computed_checksum);
    endfunction

    function void check_result(cfrp_pkg::result_t got);
      cfrp_pkg::result_t exp;
      string             diff;
      diff = "";
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", fmt(got));
        return;
      end
      exp = expected_results.pop_front();
      case (exp.kind)
        cfrp_pkg::KIND_PAYLOAD:  n_payload++;
        cfrp_pkg::KIND_FRAME_OK: n_frame_ok++;
        cfrp_pkg::KIND_CRC_BAD:  n_crc_bad++;
        default:                 n_bad_start++;
      endcase
      if (got.kind !== exp.kind) diff = {diff, " kind"};
      if (got.payload_byte !== exp.payload_byte) diff = {diff, " payload_byte"};
      if (got.payload_index !== exp.payload_index) diff = {diff, " payload_index"};
      if (got.command !== exp.command) diff = {diff, " command"};
      if (got.address !== exp.address) diff = {diff, " address"};
      if (got.param_count !== exp.param_count) diff = {diff, " param_count"};
      if (got.ack_code !== exp.ack_code) diff = {diff, " ack_code"};
      if (got.received_checksum !== exp.received_checksum) diff = {diff, " received_checksum"};
      if (got.computed_checksum !== exp.computed_checksum) diff = {diff, " computed_checksum"};
      if (diff != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch in%s", diff);
          $display("  expected %s", fmt(exp));
          $display("  actual   %s", fmt(got));
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        abandon_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  result_kind_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  payload_index_o;
  logic [7:0]  command_o;
  logic [15:0] address_o;
  logic [8:0]  param_count_o;
  logic [7:0]  ack_code_o;
  logic [15:0] received_checksum_o;
  logic [15:0] computed_checksum_o;

  frame_scoreboard sb = new();
  int bytes_sent = 0;
  int start_writes = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  crc_framed_response_parser u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .rx_byte_i          (rx_byte_i),
    .abandon_i          (abandon_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .payload_byte_o     (payload_byte_o),
    .payload_index_o    (payload_index_o),
    .command_o          (command_o),
    .address_o          (address_o),
    .param_count_o      (param_count_o),
    .ack_code_o         (ack_code_o),
    .received_checksum_o(received_checksum_o),
    .computed_checksum_o(computed_checksum_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic send_byte(input logic [7:0] b, input logic ab);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    abandon_i  <= ab;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b, ab);
    bytes_sent++;
  endtask

  // fill < 0 gives random payload and ack, cut > 0 sends only the first cut bytes
  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] addr,
                            input logic [7:0] len_byte, input int fill, input int cut,
                            input bit corrupt, input bit ab_first);
    logic [7:0]  bytes[$];
    logic [15:0] crc;
    int          n;
    int          last;
    bytes = {sb.start_val, cmd, addr[15:8], addr[7:0], len_byte};
    n = (len_byte == 8'd0) ? 256 : int'(len_byte);
    repeat (n + 1) bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    crc = 16'h0000;
    foreach (bytes[i]) crc = sb.crc_update(crc, bytes[i]);
    if (corrupt) crc ^= 16'($urandom_range(1, 65535));
    bytes.push_back(crc[15:8]);
    bytes.push_back(crc[7:0]);
    last = (cut > 0 && cut < bytes.size()) ? cut : bytes.size();
    for (int i = 0; i < last; i++) send_byte(bytes[i], (i == 0) ? ab_first : 1'b0);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_start_byte(input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.start_val = v;
    start_writes++;
  endtask

  task automatic run_traffic(input int count);
    int         stop;
    int         pick;
    logic [7:0] len;
    stop = bytes_sent + count;
    while (bytes_sent < stop) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(7, 32)) : 8'($urandom_range(1, 6));
      if (pick < 65) begin
        send_frame(8'($urandom), 16'($urandom), len, -1, 0,
                   $urandom_range(0, 6) == 0, $urandom_range(0, 9) == 0);
      end else if (pick < 82) begin
        send_frame(8'($urandom), 16'($urandom), len, -1, $urandom_range(1, 7 + int'(len)),
                   1'b0, $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) < 7) begin
          send_frame(8'($urandom), 16'($urandom), 8'($urandom_range(1, 6)), -1, 0,
                     $urandom_range(0, 6) == 0, 1'b1);
        end
      end else begin
        send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (stalls_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    cfrp_pkg::result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind              = cfrp_pkg::result_kind_e'(result_kind_o);
      got.payload_byte      = payload_byte_o;
      got.payload_index     = payload_index_o;
      got.command           = command_o;
      got.address           = address_o;
      got.param_count       = param_count_o;
      got.ack_code          = ack_code_o;
      got.received_checksum = received_checksum_o;
      got.computed_checksum = computed_checksum_o;
      sb.check_result(got);
    end
  end

  initial begin
    int failures;
    in_valid_i  <= 1'b0;
    rx_byte_i   <= 8'h00;
    abandon_i   <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 8'h00;
    rst_ni      <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: noise, extreme frames, abandon mid-frame
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_frame(8'hFF, 16'hFFFF, 8'd1, 8'hFF, 0, 1'b0, 1'b0);
    send_frame(8'h5A, 16'h1234, 8'd3, -1, 2, 1'b0, 1'b0);
    send_frame(8'h00, 16'h0000, 8'd1, 8'h00, 0, 1'b1, 1'b1);
    send_frame(8'hA5, 16'h8001, 8'd2, -1, 1, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_drained();

    write_start_byte(8'h00);
    run_traffic(130);
    wait_drained();

    write_start_byte(8'hFF);
    send_frame(8'($urandom), 16'($urandom), 8'd0, -1, 0, 1'b0, 1'b1);
    run_traffic(110);
    wait_drained();

    write_start_byte(8'($urandom));
    run_traffic(130);
    wait_drained();

    // closing stretch at full rate on both sides
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_start_byte(cfrp_pkg::StartByteRst);
    run_traffic(110);
    wait_drained();

    failures = sb.mismatches + sb.expected_results.size();
    $display("sent %0d bytes under %0d start byte settings plus the reset value",
             bytes_sent, start_writes);
    $display("checked %0d payload bytes, %0d good frames, %0d crc errors, %0d bad starts",
             sb.n_payload, sb.n_frame_ok, sb.n_crc_bad, sb.n_bad_start);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.mismatches,
               sb.expected_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
